// ===== rtl/itra_pkg.sv =====
`timescale 1ns / 1ps

package itra_pkg;

    localparam int VALUE_WIDTH_DEF = 64;
    localparam int MAX_RADIX_DEF   = 32;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;
    localparam int PC_W    = 4;
    localparam int OP_W    = 4;
    localparam int COND_W  = 3;

    localparam logic [CHAR_W-1:0]  CH_ZERO    = 8'd48;
    localparam logic [CHAR_W-1:0]  CH_UPPER_A = 8'd65;
    localparam logic [CHAR_W-1:0]  CH_MINUS   = 8'd45;
    localparam logic [CHAR_W-1:0]  CH_NONE    = 8'd0;
    localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
    localparam logic [RADIX_W-1:0] DIGIT_TEN  = 6'd10;

    localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT     = 4'd1;
    localparam logic [OP_W-1:0] OP_DIV_INIT   = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV_STEP   = 4'd3;
    localparam logic [OP_W-1:0] OP_STORE      = 4'd4;
    localparam logic [OP_W-1:0] OP_READ       = 4'd5;
    localparam logic [OP_W-1:0] OP_EMIT_SIGN  = 4'd6;
    localparam logic [OP_W-1:0] OP_EMIT_DIGIT = 4'd7;
    localparam logic [OP_W-1:0] OP_EMIT_BAD   = 4'd8;

    localparam logic [COND_W-1:0] C_NEVER    = 3'd0;
    localparam logic [COND_W-1:0] C_ALWAYS   = 3'd1;
    localparam logic [COND_W-1:0] C_BAD      = 3'd2;
    localparam logic [COND_W-1:0] C_BIT_LEFT = 3'd3;
    localparam logic [COND_W-1:0] C_QUOT_NZ  = 3'd4;
    localparam logic [COND_W-1:0] C_NO_SIGN  = 3'd5;
    localparam logic [COND_W-1:0] C_CNT_NZ   = 3'd6;

    localparam logic [PC_W-1:0] S_ACCEPT    = 4'd0;
    localparam logic [PC_W-1:0] S_CHECK     = 4'd1;
    localparam logic [PC_W-1:0] S_DIV_INIT  = 4'd2;
    localparam logic [PC_W-1:0] S_DIV_STEP  = 4'd3;
    localparam logic [PC_W-1:0] S_STORE     = 4'd4;
    localparam logic [PC_W-1:0] S_SIGN_TEST = 4'd5;
    localparam logic [PC_W-1:0] S_SIGN      = 4'd6;
    localparam logic [PC_W-1:0] S_READ      = 4'd7;
    localparam logic [PC_W-1:0] S_DIGIT     = 4'd8;
    localparam logic [PC_W-1:0] S_DONE      = 4'd9;
    localparam logic [PC_W-1:0] S_BAD       = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ctrl_word_t;

    function automatic ctrl_word_t itra_rom(input logic [PC_W-1:0] step);
        ctrl_word_t cw;
        unique case (step)
            S_ACCEPT:    cw = '{OP_ACCEPT,     C_NEVER,    S_ACCEPT};
            S_CHECK:     cw = '{OP_NOP,        C_BAD,      S_BAD};
            S_DIV_INIT:  cw = '{OP_DIV_INIT,   C_NEVER,    S_ACCEPT};
            S_DIV_STEP:  cw = '{OP_DIV_STEP,   C_BIT_LEFT, S_DIV_STEP};
            S_STORE:     cw = '{OP_STORE,      C_QUOT_NZ,  S_DIV_INIT};
            S_SIGN_TEST: cw = '{OP_NOP,        C_NO_SIGN,  S_READ};
            S_SIGN:      cw = '{OP_EMIT_SIGN,  C_NEVER,    S_ACCEPT};
            S_READ:      cw = '{OP_READ,       C_NEVER,    S_ACCEPT};
            S_DIGIT:     cw = '{OP_EMIT_DIGIT, C_CNT_NZ,   S_READ};
            S_DONE:      cw = '{OP_NOP,        C_ALWAYS,   S_ACCEPT};
            S_BAD:       cw = '{OP_EMIT_BAD,   C_ALWAYS,   S_ACCEPT};
            default:     cw = '{OP_NOP,        C_ALWAYS,   S_ACCEPT};
        endcase
        return cw;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d >= DIGIT_TEN)
            c = CH_UPPER_A + CHAR_W'(d) - CHAR_W'(DIGIT_TEN);
        else
            c = CH_ZERO + CHAR_W'(d);
        return c;
    endfunction

endpackage

// ===== rtl/integer_to_radix_ascii.sv =====
`timescale 1ns / 1ps

// Channel  Handshake           Payload
// in       in_valid/in_ready   mode, value_bits, radix
// out      out_valid/out_ready character, last, bad_radix
//
// Each digit is produced by the shared restoring divider, one quotient bit per cycle.
// Reset returns the step counter to the accept step; the digit store needs no clearing.
// A stalled output holds the sequencer on its emit step; in_ready is high only on
// the accept step.

module integer_to_radix_ascii
    import itra_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int MAX_RADIX   = MAX_RADIX_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  logic [63:0]         value_bits,
    input  logic [RADIX_W-1:0]  radix,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CHAR_W-1:0]   character,
    output logic                last,
    output logic                bad_radix
);

    localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);
    localparam int ADDR_W = $clog2(VALUE_WIDTH);
    localparam int BIT_W  = $clog2(VALUE_WIDTH);

    logic [PC_W-1:0]        pc_reg, pc_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [RADIX_W-1:0]     rem_reg;
    logic [BIT_W-1:0]       bit_reg;
    logic [RADIX_W-1:0]     radix_reg;
    logic                   neg_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;
    logic                   bad_reg;
    logic [CHAR_W-1:0]      rd_reg;
    logic [CHAR_W-1:0]      digit_mem [VALUE_WIDTH];

    ctrl_word_t             cw;
    logic                   out_free;
    logic                   is_emit;
    logic                   stall;
    logic                   cond_true;
    logic                   radix_bad;
    logic [31:0]            low32;
    logic [31:0]            mag32;
    logic [VALUE_WIDTH-1:0] mag_load;
    logic [RADIX_W:0]       trial;
    logic                   trial_ge;
    logic [RADIX_W-1:0]     rem_step;
    logic [CNT_W-1:0]       count_dec;

    always_comb
    begin
        cw        = itra_rom(pc_reg);
        out_free  = !out_valid_reg || out_ready;
        is_emit   = (cw.op == OP_EMIT_SIGN) || (cw.op == OP_EMIT_DIGIT)
                    || (cw.op == OP_EMIT_BAD);
        stall     = ((cw.op == OP_ACCEPT) && !in_valid) || (is_emit && !out_free);
        radix_bad = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_W'(MAX_RADIX));
        count_dec = count_reg - CNT_W'(1);

        low32    = value_bits[31:0];
        mag32    = low32[31] ? (32'd0 - low32) : low32;
        mag_load = mode ? value_bits[VALUE_WIDTH-1:0] : VALUE_WIDTH'(mag32);

        trial    = {rem_reg, mag_reg[VALUE_WIDTH-1]};
        trial_ge = trial >= {1'b0, radix_reg};
        rem_step = trial_ge ? RADIX_W'(trial - {1'b0, radix_reg}) : trial[RADIX_W-1:0];

        case (cw.cond)
            C_ALWAYS:   cond_true = 1'b1;
            C_BAD:      cond_true = radix_bad;
            C_BIT_LEFT: cond_true = bit_reg != '0;
            C_QUOT_NZ:  cond_true = mag_reg != '0;
            C_NO_SIGN:  cond_true = !(neg_reg && (radix_reg == RADIX_DEC));
            C_CNT_NZ:   cond_true = count_reg != '0;
            default:    cond_true = 1'b0;
        endcase

        if (stall)
            pc_next = pc_reg;
        else if (cond_true)
            pc_next = cw.target;
        else
            pc_next = pc_reg + PC_W'(1);

        count_next = count_reg;
        if (!stall && (cw.op == OP_ACCEPT))
            count_next = '0;
        else if (cw.op == OP_STORE)
            count_next = count_reg + CNT_W'(1);
        else if (cw.op == OP_READ)
            count_next = count_dec;

        out_valid_next = out_valid_reg;
        if (is_emit && out_free)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= S_ACCEPT;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cw.op)
            OP_ACCEPT:
            begin
                if (in_valid)
                begin
                    mag_reg   <= mag_load;
                    radix_reg <= radix;
                    neg_reg   <= !mode && value_bits[31];
                end
            end
            OP_DIV_INIT:
            begin
                rem_reg <= '0;
                bit_reg <= BIT_W'(VALUE_WIDTH - 1);
            end
            OP_DIV_STEP:
            begin
                rem_reg <= rem_step;
                mag_reg <= {mag_reg[VALUE_WIDTH-2:0], trial_ge};
                bit_reg <= bit_reg - BIT_W'(1);
            end
            OP_STORE:
            begin
                digit_mem[count_reg[ADDR_W-1:0]] <= digit_char(rem_reg);
            end
            OP_READ:
            begin
                rd_reg <= digit_mem[count_dec[ADDR_W-1:0]];
            end
            OP_EMIT_SIGN:
            begin
                if (out_free)
                begin
                    char_reg <= CH_MINUS;
                    last_reg <= 1'b0;
                    bad_reg  <= 1'b0;
                end
            end
            OP_EMIT_DIGIT:
            begin
                if (out_free)
                begin
                    char_reg <= rd_reg;
                    last_reg <= count_reg == '0;
                    bad_reg  <= 1'b0;
                end
            end
            OP_EMIT_BAD:
            begin
                if (out_free)
                begin
                    char_reg <= CH_NONE;
                    last_reg <= 1'b1;
                    bad_reg  <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = cw.op == OP_ACCEPT;
    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;
    assign bad_radix = bad_reg;

endmodule

// ===== dv/integer_to_radix_ascii_checker.sv =====
`timescale 1ns / 1ps

module integer_to_radix_ascii_checker
    import itra_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               mode,
    input  logic [63:0]        value_bits,
    input  logic [RADIX_W-1:0] radix,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [CHAR_W-1:0]  character,
    input  logic               last,
    input  logic               bad_radix,
    output int                 mismatches,
    output int                 chars_owed
);

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_radix;
    } ascii_char_t;

    ascii_char_t owed_q[$];

    assign chars_owed = owed_q.size();

    initial mismatches = 0;

    task automatic flag_mismatch(input string what);
        if (mismatches < PRINT_CAP)
            $display("%0t ns mismatch: %s", $time, what);
        mismatches = mismatches + 1;
    endtask

    function automatic void spell_number(input logic as_unsigned,
                                         input logic [63:0] bits,
                                         input logic [RADIX_W-1:0] base);
        logic [CHAR_W-1:0] rev [64];
        logic [63:0]       mag;
        logic [63:0]       rem;
        logic [31:0]       low;
        logic              neg;
        int                nd;
        ascii_char_t       c;
        nd  = 0;
        neg = 1'b0;
        if (base < RADIX_MIN || base > RADIX_W'(MAX_RADIX_DEF))
        begin
            c = '{CH_NONE, 1'b1, 1'b1};
            owed_q.push_back(c);
            return;
        end
        if (as_unsigned)
        begin
            mag = bits & ({64{1'b1}} >> (64 - VALUE_WIDTH_DEF));
        end
        else
        begin
            low = bits[31:0];
            neg = low[31];
            if (neg)
                low = ~low + 32'd1;
            mag = {32'd0, low};
        end
        while (mag != 64'd0 && nd < 64)
        begin
            rem = mag % 64'(base);
            mag = mag / 64'(base);
            if (rem >= 64'(DIGIT_TEN))
                rev[nd] = CH_UPPER_A + CHAR_W'(rem) - CHAR_W'(DIGIT_TEN);
            else
                rev[nd] = CH_ZERO + CHAR_W'(rem);
            nd = nd + 1;
        end
        if (nd == 0)
        begin
            rev[0] = CH_ZERO;
            nd = 1;
        end
        if (neg && base == RADIX_DEC)
        begin
            c = '{CH_MINUS, 1'b0, 1'b0};
            owed_q.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            c = '{rev[i], (i == 0), 1'b0};
            owed_q.push_back(c);
        end
    endfunction

    always @(posedge clk)
    begin : watch
        ascii_char_t due;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                spell_number(mode, value_bits, radix);
            if (out_valid && out_ready)
            begin
                if (owed_q.size() == 0)
                begin
                    flag_mismatch($sformatf("character %02h arrived with nothing owed",
                                            character));
                end
                else
                begin
                    due = owed_q.pop_front();
                    if (character !== due.character)
                        flag_mismatch($sformatf("character %02h, expected %02h",
                                                character, due.character));
                    if (last !== due.last)
                        flag_mismatch($sformatf("last %b, expected %b", last, due.last));
                    if (bad_radix !== due.bad_radix)
                        flag_mismatch($sformatf("bad_radix %b, expected %b",
                                                bad_radix, due.bad_radix));
                end
            end
        end
    end

endmodule

// ===== dv/tb_integer_to_radix_ascii.sv =====
`timescale 1ns / 1ps

module tb_integer_to_radix_ascii;
    import itra_pkg::*;

    localparam logic               MODE_SIGNED   = 1'b0;
    localparam logic               MODE_UNSIGNED = 1'b1;
    localparam logic [RADIX_W-1:0] RADIX_HEX     = 6'd16;
    localparam int RANDOM_ITEMS  = 350;
    localparam int HOLD_CYCLES   = 2500;
    localparam int SETTLE_CYCLES = 200;
    localparam int TIMEOUT_NS    = 300_000_000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               mode;
    logic [63:0]        value_bits;
    logic [RADIX_W-1:0] radix;
    logic               out_valid;
    logic               out_ready;
    logic [CHAR_W-1:0]  character;
    logic               last;
    logic               bad_radix;
    int                 mismatches;
    int                 chars_owed;
    int                 holds_asked = 0;
    int                 holds_done  = 0;

    integer_to_radix_ascii u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .value_bits (value_bits),
        .radix      (radix),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .character  (character),
        .last       (last),
        .bad_radix  (bad_radix)
    );

    integer_to_radix_ascii_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .value_bits (value_bits),
        .radix      (radix),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .character  (character),
        .last       (last),
        .bad_radix  (bad_radix),
        .mismatches (mismatches),
        .chars_owed (chars_owed)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(input logic m, input logic [63:0] v,
                             input logic [RADIX_W-1:0] r, input bit calm);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        value_bits <= v;
        radix      <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chars_owed != 0)
            @(posedge clk);
    endtask

    function automatic void roll_item(output logic m, output logic [63:0] v,
                                      output logic [RADIX_W-1:0] r);
        int          roll;
        int          width;
        logic [63:0] raw;
        logic [63:0] mask;
        logic [31:0] low;
        m   = 1'($urandom_range(0, 1));
        raw = {$urandom, $urandom};
        roll = $urandom_range(0, 99);
        if (roll < 8)
            r = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, RADIX_MIN - 1))
                                     : RADIX_W'($urandom_range(MAX_RADIX_DEF + 1, 63));
        else if (roll < 26)
            r = RADIX_DEC;
        else if (roll < 36)
            r = RADIX_HEX;
        else if (roll < 41)
            r = RADIX_MIN;
        else
            r = RADIX_W'($urandom_range(RADIX_MIN, MAX_RADIX_DEF));
        roll = $urandom_range(0, 99);
        if (roll < 5)
            width = 0;
        else if (roll < 10)
            width = 64;
        else if (roll < 75)
            width = $urandom_range(1, 24);
        else
            width = $urandom_range(25, 64);
        mask = {64{1'b1}} >> (64 - width);
        if (m == MODE_UNSIGNED)
        begin
            v = raw & mask;
        end
        else
        begin
            low = raw[31:0] & mask[31:0];
            if ($urandom_range(0, 1))
                low = ~low + 32'd1;
            if ($urandom_range(0, 29) == 0)
                low = 32'h8000_0000;
            v = {raw[63:32], low};
        end
    endfunction

    initial
    begin : receiver
        int burst;
        int gap;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (holds_done != holds_asked)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done = holds_done + 1;
            end
            else
            begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 400)
                                                   : $urandom_range(1, 12);
                out_ready <= 1'b1;
                repeat (burst) @(posedge clk);
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        logic               m;
        logic [63:0]        v;
        logic [RADIX_W-1:0] r;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_SIGNED;
        value_bits = 64'd0;
        radix      = RADIX_DEC;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_item(MODE_SIGNED,   64'd0,                   RADIX_DEC, 1'b0);
        send_item(MODE_UNSIGNED, 64'd0,                   RADIX_MIN, 1'b0);
        send_item(MODE_SIGNED,   64'h0000_0000_8000_0000, RADIX_DEC, 1'b0);
        send_item(MODE_SIGNED,   64'h0000_0000_8000_0000, RADIX_HEX, 1'b0);
        send_item(MODE_SIGNED,   64'h5A5A_5A5A_FFFF_FFFF, RADIX_DEC, 1'b0);
        send_item(MODE_SIGNED,   64'h0000_0000_7FFF_FFFF, RADIX_DEC, 1'b0);
        send_item(MODE_SIGNED,   64'hFFFF_FFFF_FFFF_FF01, RADIX_HEX, 1'b0);
        send_item(MODE_SIGNED,   64'h0000_0000_FFFF_FFD6, RADIX_MIN, 1'b0);
        send_item(MODE_SIGNED,   64'hFFFF_FFFF_0000_3039, RADIX_DEC, 1'b0);
        send_item(MODE_SIGNED,   64'hFFFF_FFFF_0000_0000, 6'd7,      1'b0);
        send_item(MODE_UNSIGNED, {64{1'b1}},              RADIX_MIN, 1'b0);
        send_item(MODE_UNSIGNED, {64{1'b1}},              6'd32,     1'b0);
        send_item(MODE_UNSIGNED, {64{1'b1}},              RADIX_DEC, 1'b0);
        send_item(MODE_UNSIGNED, {64{1'b1}},              RADIX_HEX, 1'b0);
        send_item(MODE_UNSIGNED, 64'h8000_0000_0000_0000, RADIX_MIN, 1'b0);
        send_item(MODE_UNSIGNED, 64'd31,                  6'd32,     1'b0);
        send_item(MODE_UNSIGNED, 64'd1000,                RADIX_DEC, 1'b0);
        send_item(MODE_UNSIGNED, 64'd35,                  6'd36,     1'b0);
        send_item(MODE_SIGNED,   64'd12,                  6'd0,      1'b0);
        send_item(MODE_UNSIGNED, 64'd12,                  6'd1,      1'b0);
        send_item(MODE_SIGNED,   64'd12,                  6'd33,     1'b0);
        send_item(MODE_UNSIGNED, {64{1'b1}},              6'd63,     1'b0);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 60)
                holds_asked = holds_asked + 1;
            if (i == 200)
                drain();
            roll_item(m, v, r);
            send_item(m, v, r, (i >= 120 && i < 160));
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/itra_pkg.sv
rtl/integer_to_radix_ascii.sv
dv/integer_to_radix_ascii_checker.sv
dv/tb_integer_to_radix_ascii.sv
